[hw/rtl/ledser_pkg.sv]
// package for the led driver command serialiser
// holds field widths, command and micro-program codes, the control word rom
// no dependencies
`timescale 1ns / 1ps

package ledser_pkg;

   localparam int LANES_DEF     = 9;
   localparam int WORD_BITS_DEF = 16;
   localparam int TYPE_W        = 2;
   localparam int COUNT_W       = 5;
   localparam int WORD_W        = 16;
   localparam int GREY_W        = 8;
   localparam int GREY_LANES    = 9;
   localparam int GREY_WORD_W   = 2 * GREY_W;
   localparam int SDI_W         = 9;
   localparam int MAX_CLK       = 16;
   localparam int STEP_W        = $clog2(MAX_CLK);

   typedef enum logic [TYPE_W-1:0] {
      CMD_SHIFT = 2'd0,
      CMD_MARK  = 2'd1,
      CMD_ROW   = 2'd2,
      CMD_GREY  = 2'd3
   } cmd_kind_type;

   // micro-program addresses
   typedef enum logic [2:0] {
      UPC_IDLE,
      UPC_SHIFT,
      UPC_MARK,
      UPC_ROW,
      UPC_GREY
   } upc_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_WORD,
      SRC_GREY
   } src_type;

   typedef enum logic [1:0] {
      LE_OFF,
      LE_TAIL,
      LE_ON,
      LE_FINAL
   } le_mode_type;

   typedef enum logic {
      JMP_DISPATCH,
      JMP_LOOP
   } jmp_type;

   typedef struct packed {
      logic        emit;
      src_type     src;
      le_mode_type le_mode;
      logic        row;
      jmp_type     jmp;
   } ucode_type;

   // sequencer to datapath control
   typedef struct packed {
      logic              load;
      logic              emit;
      src_type           src;
      le_mode_type       le_mode;
      logic              row;
      logic              last;
      logic [STEP_W-1:0] step;
   } ctrl_type;

   // control word rom, one word per micro-program address
   function automatic ucode_type ucode_rom(upc_type addr);
      ucode_type w;
      w = '{emit: 1'b0, src: SRC_ZERO, le_mode: LE_OFF, row: 1'b0, jmp: JMP_DISPATCH};
      case (addr)
         UPC_IDLE: begin
            w = '{emit: 1'b0, src: SRC_ZERO, le_mode: LE_OFF, row: 1'b0,
                  jmp: JMP_DISPATCH};
         end
         UPC_SHIFT: begin
            w = '{emit: 1'b1, src: SRC_WORD, le_mode: LE_TAIL, row: 1'b0,
                  jmp: JMP_LOOP};
         end
         UPC_MARK: begin
            w = '{emit: 1'b1, src: SRC_ZERO, le_mode: LE_ON, row: 1'b0,
                  jmp: JMP_LOOP};
         end
         UPC_ROW: begin
            w = '{emit: 1'b1, src: SRC_ZERO, le_mode: LE_OFF, row: 1'b1,
                  jmp: JMP_LOOP};
         end
         UPC_GREY: begin
            w = '{emit: 1'b1, src: SRC_GREY, le_mode: LE_FINAL, row: 1'b0,
                  jmp: JMP_LOOP};
         end
         default: begin
            w = '{emit: 1'b0, src: SRC_ZERO, le_mode: LE_OFF, row: 1'b0,
                  jmp: JMP_DISPATCH};
         end
      endcase
      return w;
   endfunction

   // driven lanes of the sdi field
   function automatic logic [SDI_W-1:0] lane_mask(int lanes);
      logic [SDI_W-1:0] m;
      m = '0;
      for (int k = 0; k < SDI_W; k++) begin
         m[k] = (k < lanes);
      end
      return m;
   endfunction

endpackage

[hw/rtl/ledser_sequencer.sv]
// micro-program sequencer: program counter, step counter, dispatch on command kind
// depends on ledser_pkg
`timescale 1ns / 1ps

module ledser_sequencer #(
   parameter int WORD_BITS = ledser_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [ledser_pkg::TYPE_W-1:0]       req_type,
   input  logic [ledser_pkg::COUNT_W-1:0]      req_count,
   input  logic                                output_enable,
   input  logic                                out_ready,
   output logic                                req_stall,
   output logic                                idle,
   output ledser_pkg::ctrl_type                ctrl
);

   localparam int STEP_W  = ledser_pkg::STEP_W;
   localparam int COUNT_W = ledser_pkg::COUNT_W;

   ledser_pkg::upc_type          upc_ff, upc_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [STEP_W-1:0]            end_ff, end_in;
   ledser_pkg::ucode_type        uword;
   ledser_pkg::cmd_kind_type     kind;
   logic                         cmd_ok;
   logic                         accept;
   logic                         fire;
   logic                         at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= ledser_pkg::UPC_IDLE;
         step_ff <= '0;
         end_ff  <= '0;
      end else begin
         upc_ff  <= upc_in;
         step_ff <= step_in;
         end_ff  <= end_in;
      end
   end

   always_comb begin
      uword     = ledser_pkg::ucode_rom(upc_ff);
      kind      = ledser_pkg::cmd_kind_type'(req_type);
      req_stall = (uword.jmp != ledser_pkg::JMP_DISPATCH);
      idle      = !req_stall;
      accept    = req_valid && !req_stall;
      at_end    = (step_ff == end_ff);
      fire      = uword.emit && out_ready;

      case (kind)
         ledser_pkg::CMD_SHIFT: cmd_ok = (req_count <= COUNT_W'(WORD_BITS));
         ledser_pkg::CMD_GREY:  cmd_ok = 1'b1;
         default: begin
            cmd_ok = (req_count != '0) && (req_count <= COUNT_W'(ledser_pkg::MAX_CLK));
         end
      endcase
      cmd_ok = cmd_ok && output_enable;

      upc_in  = upc_ff;
      step_in = step_ff;
      end_in  = end_ff;

      case (uword.jmp)
         ledser_pkg::JMP_DISPATCH: begin
            if (accept && cmd_ok) begin
               step_in = '0;
               case (kind)
                  ledser_pkg::CMD_SHIFT: begin
                     upc_in = ledser_pkg::UPC_SHIFT;
                     end_in = STEP_W'(WORD_BITS - 1);
                  end
                  ledser_pkg::CMD_MARK: begin
                     upc_in = ledser_pkg::UPC_MARK;
                     end_in = STEP_W'(req_count - COUNT_W'(1));
                  end
                  ledser_pkg::CMD_ROW: begin
                     upc_in = ledser_pkg::UPC_ROW;
                     end_in = STEP_W'(req_count - COUNT_W'(1));
                  end
                  default: begin
                     upc_in = ledser_pkg::UPC_GREY;
                     end_in = STEP_W'(WORD_BITS - 1);
                  end
               endcase
            end
         end
         ledser_pkg::JMP_LOOP: begin
            if (fire) begin
               if (at_end) begin
                  upc_in = ledser_pkg::UPC_IDLE;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         default: begin
            upc_in = ledser_pkg::UPC_IDLE;
         end
      endcase

      ctrl.load    = accept;
      ctrl.emit    = fire;
      ctrl.src     = uword.src;
      ctrl.le_mode = uword.le_mode;
      ctrl.row     = uword.row;
      ctrl.last    = at_end;
      ctrl.step    = step_ff;
   end

`ifndef SYNTH
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      upc_ff != ledser_pkg::UPC_IDLE |-> step_ff <= end_ff)
      else $error("step counter ran past the final clock");

   a_good_cmd_starts: assert property (@(posedge clock) disable iff (reset)
      accept && cmd_ok |=> upc_ff != ledser_pkg::UPC_IDLE)
      else $error("accepted command did not start its program");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      fire && at_end |=> upc_ff == ledser_pkg::UPC_IDLE)
      else $error("program did not return to idle after final clock");

   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      upc_ff == ledser_pkg::UPC_IDLE |-> !ctrl.emit)
      else $error("clock issued while idle");
`endif

endmodule

[hw/rtl/ledser_datapath.sv]
// datapath: word and grey shift registers, le tail compare, output register
// depends on ledser_pkg
`timescale 1ns / 1ps

module ledser_datapath #(
   parameter int LANES     = ledser_pkg::LANES_DEF,
   parameter int WORD_BITS = ledser_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ledser_pkg::ctrl_type                ctrl,
   input  logic [ledser_pkg::COUNT_W-1:0]      req_count,
   input  logic [ledser_pkg::WORD_W-1:0]       req_word,
   input  logic [ledser_pkg::GREY_W-1:0]       grey [ledser_pkg::GREY_LANES],
   input  logic                                rsp_stall,
   output logic                                out_ready,
   output logic                                rsp_valid,
   output logic [ledser_pkg::SDI_W-1:0]        rsp_sdi_lanes,
   output logic                                rsp_latch_enable,
   output logic                                rsp_row_sync,
   output logic                                rsp_last
);

   localparam int SDI_W   = ledser_pkg::SDI_W;
   localparam int GL      = ledser_pkg::GREY_LANES;
   localparam int GWW     = ledser_pkg::GREY_WORD_W;
   localparam int COUNT_W = ledser_pkg::COUNT_W;
   localparam int SUM_W   = COUNT_W + 1;
   localparam logic [SDI_W-1:0] LANE_MASK = ledser_pkg::lane_mask(LANES);

   logic [WORD_BITS-1:0]  word_ff, word_in;
   logic [GWW-1:0]        grey_ff [GL];
   logic [GWW-1:0]        grey_in [GL];
   logic [COUNT_W-1:0]    tail_ff, tail_in;
   logic                  valid_ff, valid_in;
   logic [SDI_W-1:0]      sdi_ff, sdi_in;
   logic                  le_ff, le_in;
   logic                  row_ff, row_in;
   logic                  last_ff, last_in;
   logic [SDI_W-1:0]      grey_bits;
   logic [SUM_W-1:0]      tail_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      tail_ff <= tail_in;
      sdi_ff  <= sdi_in;
      le_ff   <= le_in;
      row_ff  <= row_in;
      last_ff <= last_in;
      for (int k = 0; k < GL; k++) begin
         grey_ff[k] <= grey_in[k];
      end
   end

   always_comb begin
      out_ready = !valid_ff || !rsp_stall;

      // grey lanes beyond the nine inputs carry zero
      grey_bits = '0;
      for (int k = 0; k < GL; k++) begin
         grey_bits[k] = grey_ff[k][GWW-1];
      end

      tail_pos = SUM_W'(ctrl.step) + SUM_W'(tail_ff);

      word_in = word_ff;
      tail_in = tail_ff;
      for (int k = 0; k < GL; k++) begin
         grey_in[k] = grey_ff[k];
      end

      if (ctrl.load) begin
         word_in = req_word[WORD_BITS-1:0];
         tail_in = req_count;
         for (int k = 0; k < GL; k++) begin
            grey_in[k] = {grey[k], grey[k]};   // times 257
         end
      end else if (ctrl.emit) begin
         word_in = word_ff << 1;
         for (int k = 0; k < GL; k++) begin
            grey_in[k] = grey_ff[k] << 1;
         end
      end

      case (ctrl.src)
         ledser_pkg::SRC_WORD: sdi_in = word_ff[WORD_BITS-1] ? LANE_MASK : '0;
         ledser_pkg::SRC_GREY: sdi_in = grey_bits & LANE_MASK;
         default:              sdi_in = '0;
      endcase

      case (ctrl.le_mode)
         ledser_pkg::LE_TAIL: begin
            le_in = (tail_ff != '0) && (tail_pos >= SUM_W'(WORD_BITS));
         end
         ledser_pkg::LE_ON:    le_in = 1'b1;
         ledser_pkg::LE_FINAL: le_in = ctrl.last;
         default:              le_in = 1'b0;
      endcase

      row_in  = ctrl.row;
      last_in = ctrl.last;

      if (!ctrl.emit) begin
         sdi_in  = sdi_ff;
         le_in   = le_ff;
         row_in  = row_ff;
         last_in = last_ff;
      end

      valid_in = ctrl.emit || (valid_ff && rsp_stall);
   end

   assign rsp_valid        = valid_ff;
   assign rsp_sdi_lanes    = sdi_ff;
   assign rsp_latch_enable = le_ff;
   assign rsp_row_sync     = row_ff;
   assign rsp_last         = last_ff;

endmodule

[hw/rtl/led_driver_le_command_serializer_top.sv]
// top level of the led driver command serialiser
// instantiates ledser_sequencer and ledser_datapath, uses ledser_pkg
`timescale 1ns / 1ps

// channel   direction  handshake               carries
// req_      in         req_valid / req_stall   one command item
// rsp_      out        rsp_valid / rsp_stall   pin states of one dclk pulse
// csr_      in         csr_valid / csr_ready   output_enable write data
//
// an item is taken, then its program issues one dclk result per cycle while
// rsp_stall does not hold the output register: WORD_BITS results for a shift
// or grey latch, count results for a marker or row pulse; the next item is
// taken the cycle after the final result issues
// synchronous active-high reset: idle, output disabled, no result pending
// rsp_stall freezes the output register and the step counter until released

module led_driver_le_command_serializer_top #(
   parameter int LANES     = ledser_pkg::LANES_DEF,
   parameter int WORD_BITS = ledser_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // command items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ledser_pkg::TYPE_W-1:0]       req_type,
   input  logic [ledser_pkg::COUNT_W-1:0]      req_count,
   input  logic [ledser_pkg::WORD_W-1:0]       req_word,
   input  logic [ledser_pkg::GREY_W-1:0]       req_grey_r1,
   input  logic [ledser_pkg::GREY_W-1:0]       req_grey_g1,
   input  logic [ledser_pkg::GREY_W-1:0]       req_grey_b1,
   input  logic [ledser_pkg::GREY_W-1:0]       req_grey_r2,
   input  logic [ledser_pkg::GREY_W-1:0]       req_grey_g2,
   input  logic [ledser_pkg::GREY_W-1:0]       req_grey_b2,
   input  logic [ledser_pkg::GREY_W-1:0]       req_grey_r3,
   input  logic [ledser_pkg::GREY_W-1:0]       req_grey_g3,
   input  logic [ledser_pkg::GREY_W-1:0]       req_grey_b3,
   // per-dclk results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ledser_pkg::SDI_W-1:0]        rsp_sdi_lanes,
   output logic                                rsp_latch_enable,
   output logic                                rsp_row_sync,
   output logic                                rsp_last,
   // configuration write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_output_enable
);

   logic                        enable_ff, enable_in;
   logic                        idle;
   logic                        out_ready;
   ledser_pkg::ctrl_type        ctrl;
   logic [ledser_pkg::GREY_W-1:0] grey [ledser_pkg::GREY_LANES];

   // lane order r1 g1 b1 r2 g2 b2 r3 g3 b3
   assign grey[0] = req_grey_r1;
   assign grey[1] = req_grey_g1;
   assign grey[2] = req_grey_b1;
   assign grey[3] = req_grey_r2;
   assign grey[4] = req_grey_g2;
   assign grey[5] = req_grey_b2;
   assign grey[6] = req_grey_r3;
   assign grey[7] = req_grey_g3;
   assign grey[8] = req_grey_b3;

   // writes are taken once no command is running and no result is pending
   assign csr_ready = idle && !rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   always_comb begin
      enable_in = enable_ff;
      if (csr_valid && csr_ready) begin
         enable_in = csr_output_enable;
      end
   end

   // micro-program sequencer: dispatch, step count, control word per clock
   ledser_sequencer #(
      .WORD_BITS (WORD_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_type      (req_type),
      .req_count     (req_count),
      .output_enable (enable_ff),
      .out_ready     (out_ready),
      .req_stall     (req_stall),
      .idle          (idle),
      .ctrl          (ctrl)
   );

   // shift registers and the result register
   ledser_datapath #(
      .LANES     (LANES),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_count        (req_count),
      .req_word         (req_word),
      .grey             (grey),
      .rsp_stall        (rsp_stall),
      .out_ready        (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_sdi_lanes    (rsp_sdi_lanes),
      .rsp_latch_enable (rsp_latch_enable),
      .rsp_row_sync     (rsp_row_sync),
      .rsp_last         (rsp_last)
   );

endmodule
